[design/multi_servo_linear_ramp_top_macros.svh]
// Assertion macros for the multi-servo linear ramp top level.
// Depends on nothing; included by the top level only.
`ifndef MULTI_SERVO_LINEAR_RAMP_TOP_MACROS_SVH
`define MULTI_SERVO_LINEAR_RAMP_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define MSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/msl_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, constants and helpers for the multi-servo ramp.
// No dependencies; used by the interfaces, the divider and the top level.
package msl_pkg;

   localparam int NUM_CHANNELS_DEF = 6;
   localparam int MAX_STEPS_DEF    = 10000;
   localparam int CENTER_PULSE_DEF = 1500;

   localparam int RESULT_CAP      = 6;
   localparam int CENTER_CHANNELS = 4;
   localparam int SIDE_PULSE      = 500;

   localparam int OP_W    = 2;
   localparam int CH_W    = 3;
   localparam int PULSE_W = 12;
   localparam int DUR_W   = 16;
   localparam int POS_W   = 16;
   localparam int INC_W   = 16;
   localparam int ELAP_W  = 17;
   localparam int TICK_W  = 8;
   localparam int Q10_W   = 13;

   localparam int DIV_W = 17;
   localparam int DVS_W = 16;

   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam logic [1:0] REG_PULSE_MIN   = 2'd0;
   localparam logic [1:0] REG_PULSE_MAX   = 2'd1;
   localparam logic [1:0] REG_TICK_PERIOD = 2'd2;

   localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2500;
   localparam logic [TICK_W-1:0]  TICK_RST      = 8'd20;

   // x/10 == (x * 0xCCCD) >> 19 for every 16-bit x
   localparam logic [15:0] RECIP_10    = 16'hCCCD;
   localparam int          RECIP_SHIFT = 19;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_MOVE = 2'd1,
      OP_SET  = 2'd2,
      OP_STOP = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SET,
      S_MV_TGT,
      S_MV_DIV1,
      S_MV_STEPS,
      S_MV_DIV2,
      S_MV_INC,
      S_TK_CHK,
      S_TK_EMIT,
      S_TK_END,
      S_DV10,
      S_HALT,
      S_EMIT
   } state_type;

   // what follows the divide-by-ten step
   typedef enum logic [1:0] {
      MODE_EMIT,
      MODE_TICK,
      MODE_HALT
   } mode_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_sts_type;

   function automatic logic [PULSE_W-1:0] clamp_pulse(
      input logic [Q10_W-1:0]   q,
      input logic [PULSE_W-1:0] pmin,
      input logic [PULSE_W-1:0] pmax
   );
      logic [Q10_W-1:0] v;
      v = q;
      if (v < {1'b0, pmin}) v = {1'b0, pmin};
      if (v > {1'b0, pmax}) v = {1'b0, pmax};
      return v[PULSE_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] times10(input logic [PULSE_W-1:0] x);
      return POS_W'({x, 3'b000}) + POS_W'({x, 1'b0});
   endfunction

endpackage

[design/msl_req_if.sv]
`timescale 1ns / 1ps
// Command channel: valid/ready handshake with one command beat.
// Depends on msl_pkg for field widths.
interface msl_req_if;
   logic                            valid;
   logic                            ready;
   logic [msl_pkg::OP_W-1:0]        op;
   logic [msl_pkg::CH_W-1:0]        channel;
   logic [msl_pkg::PULSE_W-1:0]     target_pulse;
   logic [msl_pkg::DUR_W-1:0]       duration_ms;

   modport source (output valid, output op, output channel, output target_pulse,
                   output duration_ms, input ready);
   modport sink   (input valid, input op, input channel, input target_pulse,
                   input duration_ms, output ready);
endinterface

[design/msl_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with one compare-update beat.
// Depends on msl_pkg for field widths.
interface msl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [msl_pkg::CH_W-1:0]    out_channel;
   logic [msl_pkg::PULSE_W-1:0] compare_value;
   logic                        last;

   modport source (output valid, output out_channel, output compare_value,
                   output last, input ready);
   modport sink   (input valid, input out_channel, input compare_value,
                   input last, output ready);
endinterface

[design/multi_servo_linear_ramp_top.sv]
`timescale 1ns / 1ps
// Multi-channel servo ramp. Command beats are taken only in the idle state.
// Tick: visits every channel and reports each mover up to the result cap; a busy output stalls it.
// Timed move: two passes of the shared divider, for the step count and then the increment.
// Set and zero-time move write the channel and report it; stop halts one channel, or all for stop-all.
// Synchronous active-high reset restores limits, tick period and all channel state.
`include "multi_servo_linear_ramp_top_macros.svh"

module multi_servo_linear_ramp_top #(
   parameter int NUM_CHANNELS = msl_pkg::NUM_CHANNELS_DEF,
   parameter int MAX_STEPS    = msl_pkg::MAX_STEPS_DEF,
   parameter int CENTER_PULSE = msl_pkg::CENTER_PULSE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   msl_req_if.sink                      req,
   msl_rsp_if.source                    rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [msl_pkg::PADDR_W-1:0]  paddr,
   input  logic [msl_pkg::PDATA_W-1:0]  pwdata,
   output logic [msl_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(msl_pkg::RESULT_CAP + 1);
   localparam logic [msl_pkg::POS_W-1:0]   CENTER_POS = msl_pkg::POS_W'(CENTER_PULSE * 10);
   localparam logic [msl_pkg::POS_W-1:0]   SIDE_POS   =
      msl_pkg::POS_W'(msl_pkg::SIDE_PULSE * 10);
   localparam logic [msl_pkg::PULSE_W-1:0] CENTER_TGT = msl_pkg::PULSE_W'(CENTER_PULSE);
   localparam logic [msl_pkg::PULSE_W-1:0] SIDE_TGT   = msl_pkg::PULSE_W'(msl_pkg::SIDE_PULSE);

   // ---------------------------------------------------------------------
   // Configuration registers (APB). Writes land on the access phase.
   // ---------------------------------------------------------------------
   logic [msl_pkg::PULSE_W-1:0] pmin_ff, pmax_ff;
   logic [msl_pkg::TICK_W-1:0]  tick_ff;
   logic                        csr_wr;
   logic [msl_pkg::TICK_W-1:0]  tick_len;

   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite && pready;
   // a zero period counts as one millisecond
   assign tick_len = (tick_ff == '0) ? msl_pkg::TICK_W'(1) : tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff <= msl_pkg::PULSE_MIN_RST;
         pmax_ff <= msl_pkg::PULSE_MAX_RST;
         tick_ff <= msl_pkg::TICK_RST;
      end else if (csr_wr) begin
         case (paddr[3:2])
            msl_pkg::REG_PULSE_MIN:   pmin_ff <= pwdata[msl_pkg::PULSE_W-1:0];
            msl_pkg::REG_PULSE_MAX:   pmax_ff <= pwdata[msl_pkg::PULSE_W-1:0];
            msl_pkg::REG_TICK_PERIOD: tick_ff <= pwdata[msl_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         msl_pkg::REG_PULSE_MIN:   prdata = msl_pkg::PDATA_W'(pmin_ff);
         msl_pkg::REG_PULSE_MAX:   prdata = msl_pkg::PDATA_W'(pmax_ff);
         msl_pkg::REG_TICK_PERIOD: prdata = msl_pkg::PDATA_W'(tick_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Channel state, one entry per servo; only entry idx_ff is touched.
   // ---------------------------------------------------------------------
   logic [msl_pkg::POS_W-1:0]   pos_ff  [NUM_CHANNELS];
   logic [msl_pkg::PULSE_W-1:0] tgt_ff  [NUM_CHANNELS];
   logic [msl_pkg::INC_W-1:0]   inc_ff  [NUM_CHANNELS];
   logic [msl_pkg::DUR_W-1:0]   sdur_ff [NUM_CHANNELS];
   logic [msl_pkg::ELAP_W-1:0]  elap_ff [NUM_CHANNELS];

   logic [msl_pkg::POS_W-1:0]   pos_in;
   logic [msl_pkg::PULSE_W-1:0] tgt_in;
   logic [msl_pkg::INC_W-1:0]   inc_in;
   logic [msl_pkg::DUR_W-1:0]   sdur_in;
   logic [msl_pkg::ELAP_W-1:0]  elap_in;
   logic wr_pos, wr_tgt, wr_inc, wr_sdur, wr_elap;

   // sequencer and working registers
   msl_pkg::state_type          state_ff, state_in;
   msl_pkg::mode_type           mode_ff, mode_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        all_ff, all_in;
   logic [msl_pkg::PULSE_W-1:0] tp_ff, tp_in;
   logic [msl_pkg::DUR_W-1:0]   dur_ff, dur_in;
   logic                        neg_ff, neg_in;
   logic [msl_pkg::DIV_W-1:0]   mag_ff, mag_in;
   logic [msl_pkg::Q10_W-1:0]   q10_ff, q10_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;

   // one held-back tick result, so the final beat can carry last
   logic                        pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]            pend_ch_ff, pend_ch_in;
   logic [msl_pkg::PULSE_W-1:0] pend_cmp_ff, pend_cmp_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [msl_pkg::CH_W-1:0]    rsp_ch_ff, rsp_ch_in;
   logic [msl_pkg::PULSE_W-1:0] rsp_cmp_ff, rsp_cmp_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_load;
   logic                        out_free;

   msl_pkg::div_req_type        div_req;
   msl_pkg::div_sts_type        div_sts;

   msl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // ---------------------------------------------------------------------
   // Shared combinational values
   // ---------------------------------------------------------------------
   logic                        accept;
   logic                        ch_ok;
   logic                        idx_last;
   logic [msl_pkg::POS_W-1:0]   cur_pos;
   logic [msl_pkg::PULSE_W-1:0] cur_tgt;
   logic [msl_pkg::INC_W-1:0]   cur_inc;
   logic [msl_pkg::DUR_W-1:0]   cur_sdur;
   logic [msl_pkg::ELAP_W-1:0]  cur_elap;
   logic                        moving;
   logic [17:0]                 new_pos;
   logic [17:0]                 tgt10;
   logic                        hit;
   logic [msl_pkg::PULSE_W-1:0] tgt_clamped;
   logic [msl_pkg::POS_W-1:0]   tgt_clamped10;
   logic [17:0]                 diff;
   logic [msl_pkg::DVS_W-1:0]   steps;
   logic [msl_pkg::INC_W-1:0]   inc_sat;
   logic [31:0]                 recip_prod;
   logic [msl_pkg::PULSE_W-1:0] cmp_now;
   logic                        emit_ok;

   assign accept   = req.valid && req.ready;
   assign ch_ok    = (32'(req.channel) < NUM_CHANNELS);
   assign idx_last = (idx_ff == IDX_W'(NUM_CHANNELS - 1));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit_ok  = (cnt_ff < CNT_W'(msl_pkg::RESULT_CAP));

   always_comb begin
      cur_pos  = pos_ff[idx_ff];
      cur_tgt  = tgt_ff[idx_ff];
      cur_inc  = inc_ff[idx_ff];
      cur_sdur = sdur_ff[idx_ff];
      cur_elap = elap_ff[idx_ff];

      // tick: step forward, snap once the target is reached or passed
      moving  = (cur_inc != '0) && (cur_elap < {1'b0, cur_sdur});
      new_pos = {2'b00, cur_pos} + {{2{cur_inc[msl_pkg::INC_W-1]}}, cur_inc};
      tgt10   = {2'b00, msl_pkg::times10(cur_tgt)};
      hit     = cur_inc[msl_pkg::INC_W-1] ? ($signed(new_pos) <= $signed(tgt10))
                                          : ($signed(new_pos) >= $signed(tgt10));

      // move: clamped target and signed distance in tenths
      tgt_clamped   = msl_pkg::clamp_pulse({1'b0, tp_ff}, pmin_ff, pmax_ff);
      tgt_clamped10 = msl_pkg::times10(tgt_clamped);
      diff          = {2'b00, tgt_clamped10} - {2'b00, cur_pos};

      // tick count, held to [1, MAX_STEPS]
      if (div_sts.quotient == '0) begin
         steps = msl_pkg::DVS_W'(1);
      end else if (div_sts.quotient > msl_pkg::DIV_W'(MAX_STEPS)) begin
         steps = msl_pkg::DVS_W'(MAX_STEPS);
      end else begin
         steps = div_sts.quotient[msl_pkg::DVS_W-1:0];
      end

      // apply sign to the magnitude quotient and saturate to 16 bits
      if (neg_ff) begin
         if (div_sts.quotient > msl_pkg::DIV_W'(32768)) begin
            inc_sat = 16'h8000;
         end else begin
            inc_sat = msl_pkg::INC_W'(~div_sts.quotient + msl_pkg::DIV_W'(1));
         end
      end else begin
         if (div_sts.quotient > msl_pkg::DIV_W'(32767)) begin
            inc_sat = 16'h7FFF;
         end else begin
            inc_sat = div_sts.quotient[msl_pkg::INC_W-1:0];
         end
      end

      recip_prod = 32'(cur_pos) * 32'(msl_pkg::RECIP_10);
      cmp_now    = msl_pkg::clamp_pulse(q10_ff, pmin_ff, pmax_ff);
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msl_pkg::S_IDLE: begin
            if (accept) begin
               case (msl_pkg::op_type'(req.op))
                  msl_pkg::OP_TICK: state_in = msl_pkg::S_TK_CHK;
                  msl_pkg::OP_STOP: state_in = msl_pkg::S_DV10;
                  msl_pkg::OP_SET:  state_in = ch_ok ? msl_pkg::S_SET : msl_pkg::S_IDLE;
                  msl_pkg::OP_MOVE: state_in = ch_ok ? msl_pkg::S_MV_TGT : msl_pkg::S_IDLE;
                  default:          state_in = msl_pkg::S_IDLE;
               endcase
            end
         end
         msl_pkg::S_SET:      state_in = msl_pkg::S_DV10;
         msl_pkg::S_MV_TGT:   state_in = (dur_ff == '0) ?
                                         msl_pkg::S_DV10 : msl_pkg::S_MV_DIV1;
         msl_pkg::S_MV_DIV1:  if (div_sts.done) state_in = msl_pkg::S_MV_STEPS;
         msl_pkg::S_MV_STEPS: state_in = msl_pkg::S_MV_DIV2;
         msl_pkg::S_MV_DIV2:  if (div_sts.done) state_in = msl_pkg::S_MV_INC;
         msl_pkg::S_MV_INC:   state_in = msl_pkg::S_IDLE;
         msl_pkg::S_TK_CHK: begin
            if (moving && emit_ok) begin
               state_in = msl_pkg::S_DV10;
            end else if (idx_last) begin
               state_in = msl_pkg::S_TK_END;
            end
         end
         msl_pkg::S_DV10: begin
            case (mode_ff)
               msl_pkg::MODE_TICK: state_in = msl_pkg::S_TK_EMIT;
               msl_pkg::MODE_HALT: state_in = msl_pkg::S_HALT;
               default:            state_in = msl_pkg::S_EMIT;
            endcase
         end
         msl_pkg::S_TK_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               state_in = idx_last ? msl_pkg::S_TK_END : msl_pkg::S_TK_CHK;
            end
         end
         msl_pkg::S_TK_END: begin
            if (!pend_valid_ff || out_free) state_in = msl_pkg::S_IDLE;
         end
         msl_pkg::S_HALT: begin
            state_in = (all_ff && !idx_last) ? msl_pkg::S_DV10 : msl_pkg::S_IDLE;
         end
         msl_pkg::S_EMIT: begin
            if (out_free) state_in = msl_pkg::S_IDLE;
         end
         default: state_in = msl_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath actions per state
   // ---------------------------------------------------------------------
   always_comb begin
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      all_in        = all_ff;
      tp_in         = tp_ff;
      dur_in        = dur_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      q10_in        = q10_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      pend_cmp_in   = pend_cmp_ff;
      rsp_load      = 1'b0;
      rsp_ch_in     = rsp_ch_ff;
      rsp_cmp_in    = rsp_cmp_ff;
      rsp_last_in   = rsp_last_ff;
      wr_pos        = 1'b0;
      wr_tgt        = 1'b0;
      wr_inc        = 1'b0;
      wr_sdur       = 1'b0;
      wr_elap       = 1'b0;
      pos_in        = cur_pos;
      tgt_in        = cur_tgt;
      inc_in        = cur_inc;
      sdur_in       = cur_sdur;
      elap_in       = cur_elap;
      div_req       = '0;

      case (state_ff)
         msl_pkg::S_IDLE: begin
            if (accept) begin
               tp_in  = req.target_pulse;
               dur_in = req.duration_ms;
               cnt_in = '0;
               all_in = 1'b0;
               idx_in = IDX_W'(req.channel);
               case (msl_pkg::op_type'(req.op))
                  msl_pkg::OP_TICK: idx_in = '0;
                  msl_pkg::OP_STOP: begin
                     mode_in = msl_pkg::MODE_HALT;
                     if (!ch_ok) begin
                        // out-of-range channel halts every servo
                        all_in = 1'b1;
                        idx_in = '0;
                     end
                  end
                  default: mode_in = msl_pkg::MODE_EMIT;
               endcase
            end
         end

         msl_pkg::S_SET: begin
            wr_pos  = 1'b1;
            wr_tgt  = 1'b1;
            wr_inc  = 1'b1;
            wr_sdur = 1'b1;
            wr_elap = 1'b1;
            pos_in  = msl_pkg::times10(tp_ff);
            tgt_in  = tp_ff;
            inc_in  = '0;
            sdur_in = '0;
            elap_in = '0;
         end

         msl_pkg::S_MV_TGT: begin
            wr_tgt  = 1'b1;
            wr_sdur = 1'b1;
            wr_elap = 1'b1;
            tgt_in  = tgt_clamped;
            sdur_in = dur_ff;
            elap_in = '0;
            if (dur_ff == '0) begin
               // jump straight to the target
               wr_pos = 1'b1;
               wr_inc = 1'b1;
               pos_in = tgt_clamped10;
               inc_in = '0;
            end else begin
               neg_in = diff[17];
               mag_in = diff[17] ? msl_pkg::DIV_W'(~diff + 18'd1) : diff[msl_pkg::DIV_W-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = msl_pkg::DIV_W'(dur_ff);
               div_req.divisor  = msl_pkg::DVS_W'(tick_len);
            end
         end

         msl_pkg::S_MV_STEPS: begin
            div_req.start    = 1'b1;
            div_req.dividend = mag_ff;
            div_req.divisor  = steps;
         end

         msl_pkg::S_MV_INC: begin
            wr_inc = 1'b1;
            inc_in = inc_sat;
         end

         msl_pkg::S_TK_CHK: begin
            if (moving) begin
               wr_pos  = 1'b1;
               wr_elap = 1'b1;
               if (hit) begin
                  wr_inc  = 1'b1;
                  pos_in  = tgt10[msl_pkg::POS_W-1:0];
                  inc_in  = '0;
                  elap_in = msl_pkg::ELAP_W'(cur_sdur);
               end else begin
                  pos_in  = new_pos[msl_pkg::POS_W-1:0];
                  elap_in = cur_elap + msl_pkg::ELAP_W'(tick_len);
               end
            end
            if (moving && emit_ok) begin
               mode_in = msl_pkg::MODE_TICK;
            end else if (!idx_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         msl_pkg::S_DV10: begin
            // position is stable here; any write to it came in the previous state
            q10_in = recip_prod[msl_pkg::RECIP_SHIFT +: msl_pkg::Q10_W];
         end

         msl_pkg::S_TK_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_load    = 1'b1;
                  rsp_ch_in   = msl_pkg::CH_W'(pend_ch_ff);
                  rsp_cmp_in  = pend_cmp_ff;
                  rsp_last_in = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_ch_in    = idx_ff;
               pend_cmp_in   = cmp_now;
               cnt_in        = cnt_ff + CNT_W'(1);
               if (!idx_last) idx_in = idx_ff + IDX_W'(1);
            end
         end

         msl_pkg::S_TK_END: begin
            if (pend_valid_ff && out_free) begin
               rsp_load      = 1'b1;
               rsp_ch_in     = msl_pkg::CH_W'(pend_ch_ff);
               rsp_cmp_in    = pend_cmp_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end

         msl_pkg::S_HALT: begin
            wr_tgt  = 1'b1;
            wr_inc  = 1'b1;
            wr_sdur = 1'b1;
            wr_elap = 1'b1;
            tgt_in  = q10_ff[msl_pkg::PULSE_W-1:0];
            inc_in  = '0;
            sdur_in = '0;
            elap_in = '0;
            if (all_ff && !idx_last) idx_in = idx_ff + IDX_W'(1);
         end

         msl_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_ch_in   = msl_pkg::CH_W'(idx_ff);
               rsp_cmp_in  = cmp_now;
               rsp_last_in = 1'b1;
            end
         end

         default: ;
      endcase

      // hold the beat until taken, load a new one when asked
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msl_pkg::S_IDLE;
         mode_ff       <= msl_pkg::MODE_EMIT;
         idx_ff        <= '0;
         all_ff        <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pos_ff[i]  <= (i < msl_pkg::CENTER_CHANNELS) ? CENTER_POS : SIDE_POS;
            tgt_ff[i]  <= (i < msl_pkg::CENTER_CHANNELS) ? CENTER_TGT : SIDE_TGT;
            inc_ff[i]  <= '0;
            sdur_ff[i] <= '0;
            elap_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         idx_ff        <= idx_in;
         all_ff        <= all_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_pos)  pos_ff[idx_ff]  <= pos_in;
         if (wr_tgt)  tgt_ff[idx_ff]  <= tgt_in;
         if (wr_inc)  inc_ff[idx_ff]  <= inc_in;
         if (wr_sdur) sdur_ff[idx_ff] <= sdur_in;
         if (wr_elap) elap_ff[idx_ff] <= elap_in;
      end
      tp_ff       <= tp_in;
      dur_ff      <= dur_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      q10_ff      <= q10_in;
      pend_ch_ff  <= pend_ch_in;
      pend_cmp_ff <= pend_cmp_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_cmp_ff  <= rsp_cmp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req.ready         = (state_ff == msl_pkg::S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_channel   = rsp_ch_ff;
   assign rsp.compare_value = rsp_cmp_ff;
   assign rsp.last          = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `MSL_ASSERT_NOW(a_pend_flushed, clock, reset, state_ff == msl_pkg::S_IDLE, !pend_valid_ff, "held tick result left behind at idle")
   `MSL_ASSERT_NOW(a_div_done_wait, clock, reset, div_sts.done, (state_ff == msl_pkg::S_MV_DIV1) || (state_ff == msl_pkg::S_MV_DIV2), "divider finished outside a wait state")
   `MSL_ASSERT_NOW(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CNT_W'(msl_pkg::RESULT_CAP), "tick result count above cap")
   `MSL_ASSERT_NEXT(a_div_started, clock, reset, state_ff == msl_pkg::S_MV_STEPS, div_sts.busy, "second divide did not start")

endmodule

[design/msl_div.sv]
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on msl_pkg for the request and status structs.
module msl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  msl_pkg::div_req_type div_req,
   output msl_pkg::div_sts_type div_sts
);
   localparam int CNT_W = $clog2(msl_pkg::DIV_W + 1);

   logic [msl_pkg::DIV_W-1:0] quot_ff, quot_in;
   logic [msl_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [msl_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [msl_pkg::DVS_W:0]   rem_sh;
   logic [msl_pkg::DVS_W:0]   rem_sub;
   logic                      ge;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[msl_pkg::DIV_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = CNT_W'(msl_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in  = ge ? rem_sub[msl_pkg::DVS_W-1:0] : rem_sh[msl_pkg::DVS_W-1:0];
         quot_in = {quot_ff[msl_pkg::DIV_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quot_ff;

endmodule
